[rtl/page_framebuffer_dirty_sync_unit_macros.svh]
// Assertion macros shared by the frame buffer sync unit.
`ifndef PAGE_FRAMEBUFFER_DIRTY_SYNC_UNIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_DIRTY_SYNC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFDS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pfds_pkg.sv]
// Package with types, constants and helpers for the frame buffer sync unit.
`timescale 1ns / 1ps

package pfds_pkg;

  // Default panel geometry.
  localparam int PFDS_PAGES   = 8;
  localparam int PFDS_COLUMNS = 128;
  localparam int PFDS_SEGMENT = 64;

  // Rows per page are fixed at eight, so the page is the row shifted by three.
  localparam int PAGE_ROWS = 8;
  localparam int ROW_SHIFT = $clog2(PAGE_ROWS);

  // Field widths.
  localparam int FUNC_W    = 2;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 8;
  localparam int PAGE_W    = 3;
  localparam int OUT_COL_W = 7;
  localparam int DATA_W    = 8;

  // Column counters hold values up to the panel width itself.
  localparam int COL_CNT_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_PIXEL = 2'd0,
    FN_FILL  = 2'd1,
    FN_SYNC  = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    S_SWEEP = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PIX   = 4'b0100,
    S_SYNC  = 4'b1000
  } state_t;

  // Address width of a memory of the given depth.
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[rtl/pfds_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module pfds_ram #(
  parameter int WIDTH = pfds_pkg::DATA_W,
  parameter int DEPTH = pfds_pkg::PFDS_PAGES * pfds_pkg::PFDS_COLUMNS
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [pfds_pkg::addr_w(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [pfds_pkg::addr_w(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                     rdata
);
  import pfds_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/page_framebuffer_dirty_sync_unit.sv]
// Top level of the page-organized frame buffer with shadow-compare panel sync.
`timescale 1ns / 1ps
`include "page_framebuffer_dirty_sync_unit_macros.svh"

// Frame buffer and panel shadow each live in a PAGES*COLUMNS byte memory with one
// write and one read port, and every walk moves one entry per cycle through them.
// After reset the unit holds busy high while it clears both memories. A pixel item
// reads the byte, then writes back the modified byte when the pixel is solid and on
// the panel, and a fill item rewrites every byte of the frame buffer. A sync item
// walks the columns of its segment that lie on the panel, and a sync item whose page
// or segment is off the panel does not raise busy. Each result is shown for one
// cycle with out_valid and cannot be held off; a result waits until the next emitted
// column of its item is known or the walk ends, so the final result of a sync item
// (out_last high) appears in the same cycle that busy falls. Pixel, fill and unknown
// items give no results.
module page_framebuffer_dirty_sync_unit #(
  parameter int PAGES   = pfds_pkg::PFDS_PAGES,
  parameter int COLUMNS = pfds_pkg::PFDS_COLUMNS,
  parameter int SEGMENT = pfds_pkg::PFDS_SEGMENT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [pfds_pkg::FUNC_W-1:0]    in_func,
  input  logic [pfds_pkg::ROW_W-1:0]     in_row,
  input  logic [pfds_pkg::COL_W-1:0]     in_column,
  input  logic                           in_color,
  input  logic                           in_solid,
  input  logic [pfds_pkg::PAGE_W-1:0]    in_sync_page,
  input  logic                           in_segment,
  input  logic                           in_force_req,
  output logic                           out_valid,
  output logic [pfds_pkg::PAGE_W-1:0]    out_page,
  output logic [pfds_pkg::OUT_COL_W-1:0] out_column,
  output logic [pfds_pkg::DATA_W-1:0]    out_data,
  output logic                           out_last
);
  import pfds_pkg::*;

  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = addr_w(DEPTH);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [PAGE_W-1:0] p,
                                                  input logic [COL_CNT_W-1:0] c);
    return ADDR_W'(int'(p) * COLUMNS + int'(c));
  endfunction

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]    sweep_r, sweep_nxt;
  logic [DATA_W-1:0]    fill_val_r, fill_val_nxt;
  logic                 clr_shd_r, clr_shd_nxt;

  logic [ADDR_W-1:0]    pix_addr_r, pix_addr_nxt;
  logic [DATA_W-1:0]    pix_mask_r, pix_mask_nxt;
  logic                 pix_color_r, pix_color_nxt;
  logic                 pix_we_r, pix_we_nxt;

  logic [PAGE_W-1:0]    sy_page_r, sy_page_nxt;
  logic                 sy_force_r, sy_force_nxt;
  logic [COL_CNT_W-1:0] col_r, col_nxt;
  logic [COL_CNT_W-1:0] end_col_r, end_col_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [COL_CNT_W-1:0] rd_col_r, rd_col_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [COL_CNT_W-1:0] pend_col_r, pend_col_nxt;
  logic [DATA_W-1:0]    pend_data_r, pend_data_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]    out_page_r, out_page_nxt;
  logic [OUT_COL_W-1:0] out_column_r, out_column_nxt;
  logic [DATA_W-1:0]    out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 f_we, s_we;
  logic [ADDR_W-1:0]    f_waddr, f_raddr, s_waddr, s_raddr;
  logic [DATA_W-1:0]    f_wdata, f_rdata, s_wdata, s_rdata;

  logic [ROW_W-1:0]     pix_page;
  logic [COL_CNT_W-1:0] seg_start;
  logic [COL_CNT_W-1:0] seg_end;
  logic                 hit;

  pfds_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_frame_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  pfds_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_shadow_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign pix_page  = in_row >> ROW_SHIFT;
  assign seg_start = in_segment ? COL_CNT_W'(SEGMENT) : '0;
  assign seg_end   = (int'(seg_start) + SEGMENT > COLUMNS) ? COL_CNT_W'(COLUMNS)
                                                          : COL_CNT_W'(int'(seg_start) + SEGMENT);

  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    fill_val_nxt   = fill_val_r;
    clr_shd_nxt    = clr_shd_r;
    pix_addr_nxt   = pix_addr_r;
    pix_mask_nxt   = pix_mask_r;
    pix_color_nxt  = pix_color_r;
    pix_we_nxt     = pix_we_r;
    sy_page_nxt    = sy_page_r;
    sy_force_nxt   = sy_force_r;
    col_nxt        = col_r;
    end_col_nxt    = end_col_r;
    rd_vld_nxt     = 1'b0;
    rd_col_nxt     = rd_col_r;
    pend_vld_nxt   = pend_vld_r;
    pend_col_nxt   = pend_col_r;
    pend_data_nxt  = pend_data_r;
    out_valid_nxt  = 1'b0;
    out_page_nxt   = out_page_r;
    out_column_nxt = out_column_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    f_we           = 1'b0;
    f_waddr        = sweep_r;
    f_wdata        = fill_val_r;
    f_raddr        = '0;
    s_we           = 1'b0;
    s_waddr        = sweep_r;
    s_wdata        = '0;
    s_raddr        = '0;
    hit            = 1'b0;

    unique case (state_r)
      S_SWEEP: begin
        // Reset clears both memories; a fill rewrites only the frame buffer.
        f_we = 1'b1;
        s_we = clr_shd_r;
        if (sweep_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (in_func)
            FN_PIXEL: begin
              pix_addr_nxt  = cell_addr(PAGE_W'(pix_page), in_column);
              f_raddr       = pix_addr_nxt;
              pix_mask_nxt  = DATA_W'(1) << in_row[ROW_SHIFT-1:0];
              pix_color_nxt = in_color;
              pix_we_nxt    = in_solid && (int'(pix_page) < PAGES) &&
                              (int'(in_column) < COLUMNS);
              state_nxt     = S_PIX;
            end
            FN_FILL: begin
              fill_val_nxt = in_color ? '0 : '1;
              clr_shd_nxt  = 1'b0;
              sweep_nxt    = '0;
              state_nxt    = S_SWEEP;
            end
            FN_SYNC: begin
              if ((int'(in_sync_page) < PAGES) && (int'(seg_start) < COLUMNS)) begin
                sy_page_nxt  = in_sync_page;
                sy_force_nxt = in_force_req;
                col_nxt      = seg_start;
                end_col_nxt  = seg_end;
                pend_vld_nxt = 1'b0;
                state_nxt    = S_SYNC;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PIX: begin
        f_we      = pix_we_r;
        f_waddr   = pix_addr_r;
        f_wdata   = (f_rdata & ~pix_mask_r) | (pix_color_r ? '0 : pix_mask_r);
        state_nxt = S_IDLE;
      end
      S_SYNC: begin
        // The shadow write targets the column read last cycle while the read
        // fetches the next column, so the two never meet on one entry.
        f_raddr = cell_addr(sy_page_r, col_r);
        s_raddr = f_raddr;
        if (col_r < end_col_r) begin
          rd_vld_nxt = 1'b1;
          rd_col_nxt = col_r;
          col_nxt    = col_r + 1'b1;
        end
        if (rd_vld_r) begin
          hit = sy_force_r || (f_rdata != s_rdata);
          if (hit) begin
            s_we    = 1'b1;
            s_waddr = cell_addr(sy_page_r, rd_col_r);
            s_wdata = f_rdata;
            // A result goes out only once the next one is known, so that the
            // final result of the item can carry the last flag.
            if (pend_vld_r) begin
              out_valid_nxt  = 1'b1;
              out_page_nxt   = sy_page_r;
              out_column_nxt = pend_col_r[OUT_COL_W-1:0];
              out_data_nxt   = pend_data_r;
              out_last_nxt   = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_col_nxt  = rd_col_r;
            pend_data_nxt = f_rdata;
          end
        end else if (col_r >= end_col_r) begin
          if (pend_vld_r) begin
            out_valid_nxt  = 1'b1;
            out_page_nxt   = sy_page_r;
            out_column_nxt = pend_col_r[OUT_COL_W-1:0];
            out_data_nxt   = pend_data_r;
            out_last_nxt   = 1'b1;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      fill_val_r  <= '0;
      clr_shd_r   <= 1'b1;
      rd_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      fill_val_r  <= fill_val_nxt;
      clr_shd_r   <= clr_shd_nxt;
      rd_vld_r    <= rd_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_addr_r   <= pix_addr_nxt;
    pix_mask_r   <= pix_mask_nxt;
    pix_color_r  <= pix_color_nxt;
    pix_we_r     <= pix_we_nxt;
    sy_page_r    <= sy_page_nxt;
    sy_force_r   <= sy_force_nxt;
    col_r        <= col_nxt;
    end_col_r    <= end_col_nxt;
    rd_col_r     <= rd_col_nxt;
    pend_col_r   <= pend_col_nxt;
    pend_data_r  <= pend_data_nxt;
    out_page_r   <= out_page_nxt;
    out_column_r <= out_column_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_page   = out_page_r;
  assign out_column = out_column_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  `PFDS_ASSERT_NEXT(a_result_only_from_sync, clk, rst_n, state_r != S_SYNC, !out_valid_r, "result outside of a sync walk")
  `PFDS_ASSERT_SAME(a_pending_in_sync, clk, rst_n, pend_vld_r, state_r == S_SYNC, "pending result left after sync")
  `PFDS_ASSERT_SAME(a_shadow_write_src, clk, rst_n, s_we, (state_r == S_SWEEP) || rd_vld_r, "shadow written without a compared column")
  `PFDS_ASSERT_SAME(a_last_drains, clk, rst_n, out_valid_r && out_last_r, !pend_vld_r, "result pending after final result")

endmodule

[tb/tb_page_framebuffer_dirty_sync_unit.sv]
// Self-checking testbench for the page frame buffer with shadow-compare panel sync.
`timescale 1ns / 1ps

module tb_page_framebuffer_dirty_sync_unit;
  import pfds_pkg::*;

  localparam int NUM_PAGES     = PFDS_PAGES;
  localparam int NUM_COLS      = PFDS_COLUMNS;
  localparam int SEG_COLS      = PFDS_SEGMENT;
  localparam int ROWS_PER_PAGE = PAGE_ROWS;
  localparam int STORE_BYTES   = NUM_PAGES * NUM_COLS;
  localparam int USEFUL_ITEMS  = 68;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;
  localparam logic [FUNC_W-1:0] FN_UNKNOWN = 2'd3;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              color;
    logic              solid;
    logic [PAGE_W-1:0] sync_page;
    logic              segment;
    logic              force_req;
    int                gap;
    bit                hold;
  } fb_cmd_t;

  typedef struct {
    logic [PAGE_W-1:0]    page;
    logic [OUT_COL_W-1:0] column;
    logic [DATA_W-1:0]    data;
    logic                 last;
  } panel_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic [ROW_W-1:0] in_row = '0;
  logic [COL_W-1:0] in_column = '0;
  logic in_color = 1'b0;
  logic in_solid = 1'b0;
  logic [PAGE_W-1:0] in_sync_page = '0;
  logic in_segment = 1'b0;
  logic in_force_req = 1'b0;
  logic out_valid;
  logic [PAGE_W-1:0] out_page;
  logic [OUT_COL_W-1:0] out_column;
  logic [DATA_W-1:0] out_data;
  logic out_last;

  fb_cmd_t cmd_q[$];
  panel_write_t panel_write_q[$];
  fb_cmd_t cur;
  logic [DATA_W-1:0] frame_img [STORE_BYTES];
  logic [DATA_W-1:0] shadow_img [STORE_BYTES];
  int waited = 0;
  int issued = 0;
  int queued = 0;
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;

  page_framebuffer_dirty_sync_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_row(in_row), .in_column(in_column), .in_color(in_color),
    .in_solid(in_solid), .in_sync_page(in_sync_page), .in_segment(in_segment),
    .in_force_req(in_force_req), .out_valid(out_valid), .out_page(out_page),
    .out_column(out_column), .out_data(out_data), .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Walk one segment, queue a panel write for every column that changed or is forced.
  task automatic predict_sync(input logic [PAGE_W-1:0] page, input logic seg,
                              input logic frc);
    int first, col, idx, n;
    panel_write_t w;
    n = 0;
    if (int'(page) < NUM_PAGES) begin
      first = int'(seg) * SEG_COLS;
      for (int k = 0; k < SEG_COLS; k++) begin
        col = first + k;
        if (col < NUM_COLS) begin
          idx = int'(page) * NUM_COLS + col;
          if (frc || frame_img[idx] != shadow_img[idx]) begin
            w.page = page;
            w.column = col[OUT_COL_W-1:0];
            w.data = frame_img[idx];
            w.last = 1'b0;
            panel_write_q.push_back(w);
            shadow_img[idx] = frame_img[idx];
            n++;
          end
        end
      end
    end
    if (n > 0) panel_write_q[panel_write_q.size()-1].last = 1'b1;
  endtask

  task automatic apply_cmd(input fb_cmd_t c);
    int pg, bt, idx;
    case (c.func)
      FN_PIXEL: begin
        pg = int'(c.row) / ROWS_PER_PAGE;
        bt = int'(c.row) % ROWS_PER_PAGE;
        if (c.solid && pg < NUM_PAGES && int'(c.column) < NUM_COLS) begin
          idx = pg * NUM_COLS + int'(c.column);
          frame_img[idx][bt] = ~c.color;
        end
      end
      FN_FILL: begin
        for (int i = 0; i < STORE_BYTES; i++) frame_img[i] = c.color ? 8'h00 : 8'hFF;
      end
      FN_SYNC: predict_sync(c.sync_page, c.segment, c.force_req);
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic [FUNC_W-1:0] func, input int row, input int column,
                           input logic color, input logic solid, input int page,
                           input logic seg, input logic frc, input bit hold);
    fb_cmd_t c;
    c.func = func;
    c.row = row[ROW_W-1:0];
    c.column = column[COL_W-1:0];
    c.color = color;
    c.solid = solid;
    c.sync_page = page[PAGE_W-1:0];
    c.segment = seg;
    c.force_req = frc;
    c.hold = hold;
    // Alternate between back-to-back stretches and stretches with random gaps.
    if ($urandom_range(0, 15) == 0) calm = !calm;
    c.gap = calm ? 0 : $urandom_range(0, 5);
    cmd_q.push_back(c);
    if (!hold) queued++;
  endtask

  // Driver: the item on the ports is predicted at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      waited <= 0;
    end else begin
      if (start && !busy) begin
        apply_cmd(cur);
        issued++;
      end
      if (!start || !busy) begin
        if (cmd_q.size() == 0) begin
          start <= 1'b0;
        end else if (cmd_q[0].hold) begin
          start <= 1'b0;
          if (panel_write_q.size() == 0) cmd_q.delete(0);
        end else if (waited < cmd_q[0].gap) begin
          start <= 1'b0;
          waited <= waited + 1;
        end else begin
          cur = cmd_q.pop_front();
          in_func <= cur.func;
          in_row <= cur.row;
          in_column <= cur.column;
          in_color <= cur.color;
          in_solid <= cur.solid;
          in_sync_page <= cur.sync_page;
          in_segment <= cur.segment;
          in_force_req <= cur.force_req;
          start <= 1'b1;
          waited <= 0;
        end
      end
    end
  end

  // Monitor: every strobed panel write must match the oldest expected one.
  always @(posedge clk) begin
    panel_write_t w;
    if (rst_n && out_valid) begin
      if (panel_write_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected panel write: page %0d col %0d data %02h last %0b",
                   out_page, out_column, out_data, out_last);
      end else begin
        w = panel_write_q.pop_front();
        if (out_page !== w.page || out_column !== w.column || out_data !== w.data ||
            out_last !== w.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("panel write mismatch: expected page %0d col %0d data %02h last %0b, got page %0d col %0d data %02h last %0b",
                     w.page, w.column, w.data, w.last,
                     out_page, out_column, out_data, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int useful, sel;
    for (int i = 0; i < STORE_BYTES; i++) begin
      frame_img[i] = 8'h00;
      shadow_img[i] = 8'h00;
    end

    // Directed part: corners of the fields, every function and each corner case.
    queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_PIXEL, 0, 0, 1'b0, 1'b1, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_PIXEL, 255, 255, 1'b0, 1'b1, 7, 1'b1, 1'b1, 1'b0);
    queue_cmd(FN_PIXEL, 63, 127, 1'b0, 1'b1, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_PIXEL, 10, 128, 1'b0, 1'b1, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_PIXEL, 5, 5, 1'b0, 1'b0, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_PIXEL, 0, 1, 1'b1, 1'b1, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 7, 1'b1, 1'b0, 1'b0);
    queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 7, 1'b1, 1'b1, 1'b0);
    queue_cmd(FN_UNKNOWN, 255, 255, 1'b1, 1'b1, 7, 1'b1, 1'b1, 1'b0);
    queue_cmd(FN_FILL, 255, 255, 1'b0, 1'b0, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 3, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_FILL, 0, 0, 1'b1, 1'b1, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_PIXEL, 31, 70, 1'b0, 1'b1, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_PIXEL, 24, 127, 1'b0, 1'b1, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 3, 1'b1, 1'b0, 1'b0);
    queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 3, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b1, 1'b1);
    queue_cmd(FN_PIXEL, 56, 64, 1'b0, 1'b1, 0, 1'b0, 1'b0, 1'b0);
    queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 7, 1'b1, 1'b0, 1'b0);

    // Random part: mostly on-panel pixel writes and syncs, with noise mixed in.
    useful = 0;
    while (useful < USEFUL_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 52) begin
        queue_cmd(FN_PIXEL, $urandom_range(0, NUM_PAGES * ROWS_PER_PAGE - 1),
                  $urandom_range(0, NUM_COLS - 1), 1'($urandom_range(0, 1)), 1'b1,
                  $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0);
        useful++;
      end else if (sel < 60) begin
        queue_cmd(FN_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0);
      end else if (sel < 88) begin
        queue_cmd(FN_SYNC, $urandom_range(0, 255), $urandom_range(0, 255),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 7) == 0, 1'b0);
        useful++;
      end else if (sel < 92) begin
        queue_cmd(FN_FILL, $urandom_range(0, 255), $urandom_range(0, 255),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0);
        useful++;
      end else if (sel < 96) begin
        queue_cmd(FN_UNKNOWN, $urandom_range(0, 255), $urandom_range(0, 255),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 7), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0);
      end else begin
        queue_cmd(FN_SYNC, 0, 0, 1'b0, 1'b0, 0, 1'b0, 1'b0, 1'b1);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (issued < queued) @(posedge clk);
    // One more edge so that busy reflects the last accepted item.
    @(posedge clk);
    while (panel_write_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/pfds_pkg.sv
rtl/pfds_ram.sv
rtl/page_framebuffer_dirty_sync_unit.sv
tb/tb_page_framebuffer_dirty_sync_unit.sv
